// ===== hdl/crcl_pkg.sv =====
package crcl_pkg;

    // Frame length ceiling and the fixed byte codes of the link.
    localparam int unsigned MAX_FRAME_LEN = 256;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  ACK_SUCCESS   = 8'h30;
    localparam logic [7:0]  ACK_CRC_ERROR = 8'hC2;
    localparam logic [7:0]  ACK_NONE      = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RX_LEN        = 2'd0,
        CFG_RX_CHECK_CRC  = 2'd1,
        CFG_TX_APPEND_CRC = 2'd2
    } cfg_index_t;

    // Request codes on the input stream.
    typedef enum logic [1:0] {
        REQ_RX_BYTE    = 2'd0,
        REQ_RX_TIMEOUT = 2'd1,
        REQ_TX_BYTE    = 2'd2,
        REQ_TX_END     = 2'd3
    } req_type_t;

    // Result kinds on the output stream.
    typedef enum logic [1:0] {
        KIND_RX_PAYLOAD = 2'd0,
        KIND_TX_BYTE    = 2'd1,
        KIND_RX_DONE    = 2'd2
    } kind_t;

    // Frame completion codes.
    typedef enum logic [1:0] {
        ST_SUCCESS   = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_CRC_ERROR = 2'd2,
        ST_TIMEOUT   = 2'd3
    } status_t;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        status_t     status;
        logic        last;
    } result_t;

    // One queued command: a first result and an optional second transmit byte.
    typedef struct packed {
        result_t     first;
        logic        has_second;
        logic [7:0]  second_byte;
    } cmd_t;

    // CRC-16 update over one byte, LSB first, reflected polynomial.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        logic        mix;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++)
        begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[15:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16_framed_link_checker.sv =====
// A result is written into a command queue slot, then loaded into the output register, before it is on m_tvalid.
// One input transaction is taken per cycle while s_tready is high; a transmit frame end with CRC
// append occupies the output for two results, and a four-entry command queue absorbs it.
// Stalls on the output back up through the queue to s_tready only once the queue is full.
// Reset (rst_n low, asynchronous): rx_len = 1, CRC check and append off, receive count,
// receive CRC and transmit CRC cleared, queue and output register emptied.
module crc16_framed_link_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_wdata,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // byte_value[7:0], byte_index[15:8], status[17:16]
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast    // last
);
    import crcl_pkg::*;

    logic q_full, q_push, q_pop, q_head_valid;
    cmd_t q_cmd, q_head_cmd;

    // Front: classify requests and keep the CRC state.
    crcl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Command queue between the two halves.
    crcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back: emit results through the output register.
    crcl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== hdl/crcl_front.sv =====
module crcl_front (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration writes.
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [8:0]             cfg_wdata,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte[7:0]
    input  logic [1:0]             s_tuser,   // req_type[1:0]
    // Command queue write side.
    input  logic                   q_full,
    output logic                   q_push,
    output crcl_pkg::cmd_t         q_cmd
);
    import crcl_pkg::*;

    logic [8:0]  rx_len_reg;
    logic        rx_check_crc_reg;
    logic        tx_append_crc_reg;

    logic [8:0]  rx_count_reg, rx_count_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] tx_crc_reg, tx_crc_next;

    logic        accept;
    logic [8:0]  len_eff;
    logic [9:0]  len_plus_crc;
    logic [15:0] rx_crc_upd;
    logic [15:0] tx_crc_upd;
    req_type_t   req;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_len_reg        <= 9'd1;
            rx_check_crc_reg  <= 1'b0;
            tx_append_crc_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RX_LEN:        rx_len_reg        <= cfg_wdata;
                CFG_RX_CHECK_CRC:  rx_check_crc_reg  <= cfg_wdata[0];
                CFG_TX_APPEND_CRC: tx_append_crc_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign s_tready     = !q_full;
    assign accept       = s_tvalid && s_tready;
    assign req          = req_type_t'(s_tuser);
    assign len_eff      = (rx_len_reg > 9'(MAX_FRAME_LEN)) ? 9'(MAX_FRAME_LEN) : rx_len_reg;
    assign len_plus_crc = {1'b0, len_eff} + 10'd2;
    assign rx_crc_upd   = crc_update(rx_crc_reg, s_tdata);
    assign tx_crc_upd   = crc_update(tx_crc_reg, s_tdata);

    // Classify the request, update the running state and form the command.
    always_comb
    begin
        rx_count_next = rx_count_reg;
        rx_crc_next   = rx_crc_reg;
        tx_crc_next   = tx_crc_reg;
        q_push        = 1'b0;
        q_cmd         = '0;
        q_cmd.first.last = 1'b1;
        if (accept)
        begin
            unique case (req)
                REQ_RX_BYTE:
                begin
                    if (rx_count_reg < len_eff)
                    begin
                        q_push                 = 1'b1;
                        q_cmd.first.kind       = KIND_RX_PAYLOAD;
                        q_cmd.first.byte_value = s_tdata;
                        q_cmd.first.byte_index = rx_count_reg[7:0];
                        rx_crc_next            = rx_crc_upd;
                        rx_count_next          = rx_count_reg + 9'd1;
                    end
                    else if (rx_check_crc_reg && ({1'b0, rx_count_reg} < len_plus_crc))
                    begin
                        rx_crc_next   = rx_crc_upd;
                        rx_count_next = rx_count_reg + 9'd1;
                    end
                    else
                    begin
                        q_push           = 1'b1;
                        q_cmd.first.kind = KIND_RX_DONE;
                        if (rx_check_crc_reg && (rx_crc_reg != 16'd0))
                        begin
                            q_cmd.first.byte_value = ACK_CRC_ERROR;
                            q_cmd.first.status     = ST_CRC_ERROR;
                        end
                        else
                        begin
                            q_cmd.first.byte_value = s_tdata;
                            q_cmd.first.status     = (s_tdata == ACK_SUCCESS) ? ST_SUCCESS
                                                                             : ST_REFUSED;
                        end
                        rx_count_next = 9'd0;
                        rx_crc_next   = 16'd0;
                    end
                end
                REQ_RX_TIMEOUT:
                begin
                    q_push                 = 1'b1;
                    q_cmd.first.kind       = KIND_RX_DONE;
                    q_cmd.first.byte_value = ACK_NONE;
                    q_cmd.first.status     = ST_TIMEOUT;
                    rx_count_next          = 9'd0;
                    rx_crc_next            = 16'd0;
                end
                REQ_TX_BYTE:
                begin
                    q_push                 = 1'b1;
                    q_cmd.first.kind       = KIND_TX_BYTE;
                    q_cmd.first.byte_value = s_tdata;
                    tx_crc_next            = tx_crc_upd;
                end
                REQ_TX_END:
                begin
                    q_push                 = tx_append_crc_reg;
                    q_cmd.first.kind       = KIND_TX_BYTE;
                    q_cmd.first.byte_value = tx_crc_reg[7:0];
                    q_cmd.first.last       = 1'b0;
                    q_cmd.has_second       = 1'b1;
                    q_cmd.second_byte      = tx_crc_reg[15:8];
                    tx_crc_next            = 16'd0;
                end
                default: ;
            endcase
        end
    end

    // Running receive and transmit state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= 9'd0;
            rx_crc_reg   <= 16'd0;
            tx_crc_reg   <= 16'd0;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            rx_crc_reg   <= rx_crc_next;
            tx_crc_reg   <= tx_crc_next;
        end
    end

    // A command is only written for an accepted transaction.
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> accept)
        else $error("command written without an accepted transaction");

    // A timeout leaves the receive side cleared.
    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == REQ_RX_TIMEOUT))
            |=> (rx_count_reg == 9'd0) && (rx_crc_reg == 16'd0))
        else $error("receive state not cleared after timeout");

    // Frame end always leaves the transmit CRC cleared.
    a_tx_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == REQ_TX_END)) |=> (tx_crc_reg == 16'd0))
        else $error("transmit CRC not cleared at frame end");

endmodule

// ===== hdl/crcl_queue.sv =====
module crcl_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crcl_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output crcl_pkg::cmd_t   head_cmd
);
    import crcl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Occupancy follows the push and pop pair.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

// ===== hdl/crcl_back.sv =====
module crcl_back (
    input  logic             clk,
    input  logic             rst_n,
    // Command queue read side.
    input  logic             head_valid,
    input  crcl_pkg::cmd_t   head_cmd,
    output logic             pop,
    // Output stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // byte_value[7:0], byte_index[15:8], status[17:16]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast    // last
);
    import crcl_pkg::*;

    logic    m_tvalid_reg, m_tvalid_next;
    logic    second_reg, second_next;
    result_t out_reg, out_next;
    logic    load;

    assign load = !m_tvalid_reg || m_tready;

    // Step through the queued command: one result, or the low then high CRC byte.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        second_next   = second_reg;
        out_next      = out_reg;
        pop           = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                m_tvalid_next       = 1'b1;
                out_next            = '0;
                out_next.kind       = KIND_TX_BYTE;
                out_next.byte_value = head_cmd.second_byte;
                out_next.last       = 1'b1;
                second_next         = 1'b0;
                pop                 = 1'b1;
            end
            else if (head_valid)
            begin
                m_tvalid_next = 1'b1;
                out_next      = head_cmd.first;
                second_next   = head_cmd.has_second;
                pop           = !head_cmd.has_second;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            second_reg   <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            second_reg   <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.byte_index, out_reg.byte_value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // The high CRC byte is only pending while the low byte is on the bus.
    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (m_tvalid_reg && !out_reg.last && head_valid))
        else $error("high CRC byte pending without its low byte");

    // The queue is only released as the last result of the command is loaded into the output register.
    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid_reg && out_reg.last))
        else $error("command released before its last result");

    a_second_kind: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (out_reg.kind == KIND_TX_BYTE))
        else $error("two-result command that is not a transmit CRC");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int REPORT_MAX     = 10;

    // Ports of the block.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    cfg_index_t  cfg_index = CFG_RX_LEN;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    req_type_t   s_tuser   = REQ_RX_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Mirror of the link configuration and the framing state.
    logic [8:0]  rx_len_m     = 9'd1;
    logic        rx_check_m   = 1'b0;
    logic        tx_append_m  = 1'b0;
    logic [8:0]  rx_count_m   = '0;
    logic [15:0] rx_crc_m     = '0;
    logic [15:0] tx_crc_m     = '0;

    result_t     pending_results[$];
    int          mismatches    = 0;
    int          sent_items    = 0;
    int          idle_streak   = 0;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    logic        hold_req      = 1'b0;
    logic        hold_ack      = 1'b0;
    int          hold_left     = 0;

    crc16_framed_link_checker dut (.*);

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // CRC-16/ARC over one byte: fold the byte into the low bits, then shift it out.
    function automatic logic [15:0] crc16_arc_next(logic [15:0] acc, logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Payload length in force, saturated at the largest frame.
    function automatic int unsigned eff_rx_len();
        return (rx_len_m > MAX_FRAME_LEN) ? MAX_FRAME_LEN : int'(rx_len_m);
    endfunction

    // Works out the results of one request and advances the framing state.
    function automatic void predict_request(req_type_t rt, logic [7:0] d);
        int unsigned len;
        result_t     r;
        len = eff_rx_len();
        r = '0;
        r.last = 1'b1;
        case (rt)
            REQ_RX_BYTE:
            begin
                if (rx_count_m < len)
                begin
                    r.kind       = KIND_RX_PAYLOAD;
                    r.byte_value = d;
                    r.byte_index = rx_count_m[7:0];
                    pending_results.push_back(r);
                    rx_crc_m   = crc16_arc_next(rx_crc_m, d);
                    rx_count_m = rx_count_m + 9'd1;
                end
                else if (rx_check_m && rx_count_m < len + 2)
                begin
                    // CRC bytes only feed the remainder.
                    rx_crc_m   = crc16_arc_next(rx_crc_m, d);
                    rx_count_m = rx_count_m + 9'd1;
                end
                else
                begin
                    // Acknowledge byte closes the frame.
                    r.kind = KIND_RX_DONE;
                    if (rx_check_m && rx_crc_m != 16'h0000)
                    begin
                        r.byte_value = ACK_CRC_ERROR;
                        r.status     = ST_CRC_ERROR;
                    end
                    else
                    begin
                        r.byte_value = d;
                        r.status     = (d == ACK_SUCCESS) ? ST_SUCCESS : ST_REFUSED;
                    end
                    pending_results.push_back(r);
                    rx_count_m = '0;
                    rx_crc_m   = '0;
                end
            end
            REQ_RX_TIMEOUT:
            begin
                r.kind       = KIND_RX_DONE;
                r.byte_value = ACK_NONE;
                r.status     = ST_TIMEOUT;
                pending_results.push_back(r);
                rx_count_m = '0;
                rx_crc_m   = '0;
            end
            REQ_TX_BYTE:
            begin
                r.kind       = KIND_TX_BYTE;
                r.byte_value = d;
                pending_results.push_back(r);
                tx_crc_m = crc16_arc_next(tx_crc_m, d);
            end
            default:
            begin
                // Frame end: CRC goes out low byte first when appending.
                if (tx_append_m)
                begin
                    r.kind       = KIND_TX_BYTE;
                    r.byte_value = tx_crc_m[7:0];
                    r.last       = 1'b0;
                    pending_results.push_back(r);
                    r.byte_value = tx_crc_m[15:8];
                    r.last       = 1'b1;
                    pending_results.push_back(r);
                end
                tx_crc_m = '0;
            end
        endcase
    endfunction

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Prediction, result checking and the watchdog.
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                seen.kind       = kind_t'(m_tuser);
                seen.byte_value = m_tdata[7:0];
                seen.byte_index = m_tdata[15:8];
                seen.status     = status_t'(m_tdata[17:16]);
                seen.last       = m_tlast;
                if (pending_results.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                    begin
                        $display("%0t: unexpected result kind=%0d value=%02h index=%0d st=%0d last=%0b",
                                 $realtime, seen.kind, seen.byte_value, seen.byte_index,
                                 seen.status, seen.last);
                    end
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want)
                    begin
                        if (mismatches < REPORT_MAX)
                        begin
                            $display("%0t: expected kind=%0d value=%02h index=%0d st=%0d last=%0b",
                                     $realtime, want.kind, want.byte_value, want.byte_index,
                                     want.status, want.last);
                            $display("%0t:   actual kind=%0d value=%02h index=%0d st=%0d last=%0b",
                                     $realtime, seen.kind, seen.byte_value, seen.byte_index,
                                     seen.status, seen.last);
                        end
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_streak = 0;
            end
            else
            begin
                idle_streak++;
            end
            if (idle_streak >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_streak);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one request, after a random gap, and waits until it is taken.
    task automatic send_req(req_type_t rt, logic [7:0] d);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every expected result, then lets in-flight frame ends settle.
    task automatic drain();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [8:0] value);
        stop_sending();
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RX_LEN:        rx_len_m    = value;
            CFG_RX_CHECK_CRC:  rx_check_m  = value[0];
            CFG_TX_APPEND_CRC: tx_append_m = value[0];
            default: ;
        endcase
    endtask

    task automatic set_idling(int src, int snk);
        src_idle_pct = src;
        snk_stall_pct <= snk;
    endtask

    // One received frame from a clean start: payload, CRC when checked, acknowledge.
    // A non-negative abort position cuts the frame short with a timeout.
    task automatic send_rx_frame(int abort_at, bit bad_crc, logic [7:0] ack);
        logic [15:0] acc;
        logic [7:0]  b;
        int unsigned len;
        acc = '0;
        len = eff_rx_len();
        for (int i = 0; i < len; i++)
        begin
            if (i == abort_at)
            begin
                send_req(REQ_RX_TIMEOUT, 8'($urandom));
                return;
            end
            b   = 8'($urandom);
            acc = crc16_arc_next(acc, b);
            send_req(REQ_RX_BYTE, b);
            if ($urandom_range(7) == 0)
            begin
                send_req(REQ_TX_BYTE, 8'($urandom));
            end
        end
        if (rx_check_m)
        begin
            if (bad_crc)
            begin
                acc = acc ^ (16'd1 << $urandom_range(15));
            end
            send_req(REQ_RX_BYTE, acc[7:0]);
            send_req(REQ_RX_BYTE, acc[15:8]);
        end
        send_req(REQ_RX_BYTE, ack);
    endtask

    task automatic send_tx_frame();
        repeat ($urandom_range(5)) send_req(REQ_TX_BYTE, 8'($urandom));
        send_req(REQ_TX_END, 8'($urandom));
    endtask

    // Byte extremes, every request, every completion status.
    task automatic test_directed();
        send_req(REQ_RX_TIMEOUT, 8'hFF);
        send_req(REQ_RX_BYTE, 8'h00);
        send_req(REQ_RX_BYTE, ACK_SUCCESS);
        send_req(REQ_RX_BYTE, 8'hFF);
        send_req(REQ_RX_BYTE, 8'hCF);
        send_req(REQ_TX_BYTE, 8'h00);
        send_req(REQ_TX_BYTE, 8'hFF);
        send_req(REQ_TX_END, 8'hFF);
        write_reg(CFG_TX_APPEND_CRC, 9'd1);
        write_reg(CFG_RX_CHECK_CRC, 9'd1);
        write_reg(CFG_RX_LEN, 9'd2);
        send_req(REQ_TX_BYTE, 8'hA5);
        send_req(REQ_TX_BYTE, 8'h5A);
        send_req(REQ_TX_END, 8'h00);
        // Empty transmit frame appends the CRC of nothing.
        send_req(REQ_TX_END, 8'h00);
        send_rx_frame(-1, 1'b0, ACK_SUCCESS);
        send_rx_frame(-1, 1'b1, ACK_SUCCESS);
        send_rx_frame(1, 1'b0, ACK_SUCCESS);
        // Zero length and no check: the first byte is the acknowledge.
        write_reg(CFG_RX_LEN, 9'd0);
        write_reg(CFG_RX_CHECK_CRC, 9'd0);
        send_req(REQ_RX_BYTE, 8'h55);
    endtask

    // Settings changed while a receive frame is half done.
    task automatic test_mid_frame_config();
        write_reg(CFG_RX_LEN, 9'd6);
        repeat (3) send_req(REQ_RX_BYTE, 8'($urandom));
        write_reg(CFG_RX_LEN, 9'd1);
        send_req(REQ_RX_BYTE, ACK_SUCCESS);
        write_reg(CFG_RX_CHECK_CRC, 9'd1);
        write_reg(CFG_RX_LEN, 9'd2);
        repeat (3) send_req(REQ_RX_BYTE, 8'($urandom));
        write_reg(CFG_RX_CHECK_CRC, 9'd0);
        send_req(REQ_RX_BYTE, ACK_SUCCESS);
        // Shrinking the payload while checking lands the count past the CRC bytes.
        write_reg(CFG_RX_CHECK_CRC, 9'd1);
        write_reg(CFG_RX_LEN, 9'd4);
        repeat (3) send_req(REQ_RX_BYTE, 8'($urandom));
        write_reg(CFG_RX_LEN, 9'd1);
        send_req(REQ_RX_BYTE, ACK_SUCCESS);
    endtask

    // Largest length register value saturates to a full-size frame.
    task automatic test_long_frame();
        write_reg(CFG_RX_LEN, 9'h1FF);
        write_reg(CFG_RX_CHECK_CRC, 9'd1);
        send_rx_frame(-1, 1'b0, ACK_SUCCESS);
    endtask

    // Long output hold-off with the sender still pushing, then a full pause.
    task automatic test_backpressure();
        set_idling(0, 0);
        write_reg(CFG_RX_LEN, 9'd3);
        hold_req <= ~hold_req;
        repeat (12) send_req(REQ_TX_BYTE, 8'($urandom));
        send_req(REQ_TX_END, 8'($urandom));
        send_rx_frame(-1, 1'b0, ACK_SUCCESS);
        stop_sending();
        drain();
        hold_req <= ~hold_req;
        send_rx_frame(-1, 1'b0, 8'($urandom));
        send_tx_frame();
    endtask

    // Mostly well-formed frames with random content, some broken ones and noise.
    task automatic test_random(int src, int snk);
        int          stop_at;
        int unsigned pick;
        int unsigned len;
        req_type_t   rt;
        set_idling(src, snk);
        repeat (2)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                write_reg(CFG_RX_LEN, 9'd0);
            else if (pick == 9)
                write_reg(CFG_RX_LEN, 9'($urandom_range(7, 24)));
            else
                write_reg(CFG_RX_LEN, 9'($urandom_range(1, 6)));
            write_reg(CFG_RX_CHECK_CRC, 9'($urandom_range(1)));
            write_reg(CFG_TX_APPEND_CRC, 9'($urandom_range(1)));
            // Start from a clean receive state.
            send_req(REQ_RX_TIMEOUT, 8'($urandom));
            stop_at = sent_items + 70;
            while (sent_items < stop_at)
            begin
                pick = $urandom_range(99);
                len  = eff_rx_len();
                if (pick < 45)
                begin
                    send_rx_frame(($urandom_range(9) == 0 && len > 0) ?
                                  int'($urandom_range(len - 1)) : -1,
                                  $urandom_range(9) == 0,
                                  ($urandom_range(4) == 0) ? 8'($urandom) : ACK_SUCCESS);
                end
                else if (pick < 80)
                begin
                    send_tx_frame();
                end
                else
                begin
                    rt = req_type_t'($urandom_range(3));
                    send_req(rt, 8'($urandom));
                    if (rt == REQ_RX_BYTE)
                    begin
                        send_req(REQ_RX_TIMEOUT, 8'($urandom));
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mid_frame_config();
        test_long_frame();
        test_backpressure();
        test_random(0, 0);
        test_random(86, 0);
        test_random(0, 86);
        test_random(33, 33);
        stop_sending();
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/crcl_pkg.sv
hdl/crcl_front.sv
hdl/crcl_queue.sv
hdl/crcl_back.sv
hdl/crc16_framed_link_checker.sv
bench/tb_top.sv
